### hw/rtl/pkst_pkg.sv
// shared constants and types of the pressed-key set tracker
package pkst_pkg;

  localparam int MAX_KEYS  = 16;
  localparam int KEY_AW    = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int CODE_W    = 10;
  localparam int TIME_W    = 32;
  localparam int SERIAL_W  = 32;
  localparam int MASK_W    = 32;
  localparam int MOD_W     = 8;
  localparam int NUM_REGS  = 8;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 4;
  localparam int LOCK_BIT  = 1;

  localparam logic RESULT_KEY = 1'b0;
  localparam logic RESULT_MOD = 1'b1;

  localparam logic [IDX_W-1:0] IDX_UNMAPPED = IDX_W'(32);

  typedef logic [NUM_REGS-1:0][IDX_W-1:0] idx_arr_t;

  typedef struct packed {
    logic [MASK_W-1:0] depressed;
    logic [MASK_W-1:0] locked;
  } masks_t;

endpackage

### hw/rtl/pkst_if.sv
// channel interfaces: key events in, results out, register writes

interface pkst_in_if;
  logic                          valid;
  logic                          ready;
  logic                          pressed;
  logic [pkst_pkg::CODE_W-1:0]   keycode;
  logic [pkst_pkg::TIME_W-1:0]   timestamp;
  logic [pkst_pkg::MOD_W-1:0]    modifier_bits;

  modport source (output valid, pressed, keycode, timestamp, modifier_bits, input ready);
  modport sink   (input valid, pressed, keycode, timestamp, modifier_bits, output ready);
endinterface

interface pkst_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [pkst_pkg::CODE_W-1:0]   key_code;
  logic                          key_down;
  logic [pkst_pkg::TIME_W-1:0]   event_time;
  logic [pkst_pkg::SERIAL_W-1:0] serial_number;
  logic [pkst_pkg::MASK_W-1:0]   depressed_mask;
  logic [pkst_pkg::MASK_W-1:0]   locked_mask;
  logic                          unknown_release;
  logic                          table_overflow;
  logic                          last_of_run;

  modport source (output valid, result_kind, key_code, key_down, event_time, serial_number,
                  depressed_mask, locked_mask, unknown_release, table_overflow,
                  last_of_run, input ready);
  modport sink   (input valid, result_kind, key_code, key_down, event_time, serial_number,
                  depressed_mask, locked_mask, unknown_release, table_overflow,
                  last_of_run, output ready);
endinterface

interface pkst_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pkst_pkg::CFG_IDX_W-1:0] index;
  logic [pkst_pkg::IDX_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/pkst_ram.sv
// generic single-write, single-read ram with registered read data
module pkst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/pkst_modmap.sv
// maps the eight modifier bits onto depressed and locked masks
module pkst_modmap (
  input  logic [pkst_pkg::MOD_W-1:0] mods,
  input  pkst_pkg::idx_arr_t         idx,
  output pkst_pkg::masks_t           masks
);

  always_comb begin
    masks = '0;
    for (int b = 0; b < pkst_pkg::NUM_REGS; b++) begin
      // index values of 32 and up select no bit
      if (mods[b] && (idx[b] < pkst_pkg::IDX_UNMAPPED)) begin
        if (b == pkst_pkg::LOCK_BIT) begin
          masks.locked[idx[b][4:0]] = 1'b1;
        end else begin
          masks.depressed[idx[b][4:0]] = 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/pressed_key_set_tracker.sv
// top level: key table sequencer with serial and modifier tracking
//
// Key events arrive on in_ch (valid/ready); a transfer takes pressed, keycode,
// timestamp and modifier_bits. in_ch.ready is high only while the sequencer
// is idle, so one event is worked on at a time. The event's keycode is
// compared against the stored keys one entry per cycle through the table
// ram; the scan stops early on a match. A decide state, a slot move on a
// known release and one or two result states follow, and the sequencer
// goes back to idle before it takes the next transfer.
// A press of a key already down is an auto-repeat: it ends after the scan
// with no result. Otherwise a modifier result comes first if the modifier
// bits changed, then the key result with last_of_run set.
// Results leave through a one-entry output register on out_ch; when the
// receiver stalls the register holds and the sequencer waits to load it.
// cfg_ch is always ready; writes to indexes beyond seven are ignored and
// writes are expected only while no event is in flight.
// Reset (rst_n low, synchronous) empties the table, clears the serial
// counter and the remembered modifier bits and sets every index to 32.
module pressed_key_set_tracker (
  input logic        clk,
  input logic        rst_n,
  pkst_in_if.sink    in_ch,
  pkst_out_if.source out_ch,
  pkst_cfg_if.sink   cfg_ch
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SCAN     = 6'b000010,
    ST_DECIDE   = 6'b000100,
    ST_MOVE     = 6'b001000,
    ST_EMIT_MOD = 6'b010000,
    ST_EMIT_KEY = 6'b100000
  } state_t;

  typedef struct packed {
    logic                          kind;
    logic [pkst_pkg::CODE_W-1:0]   code;
    logic                          down;
    logic [pkst_pkg::TIME_W-1:0]   ev_time;
    logic [pkst_pkg::SERIAL_W-1:0] serial;
    logic [pkst_pkg::MASK_W-1:0]   dep;
    logic [pkst_pkg::MASK_W-1:0]   lck;
    logic                          unk;
    logic                          ovf;
    logic                          last;
  } result_t;

  state_t                        state_r, state_nxt;
  logic [pkst_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [pkst_pkg::CNT_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic                          pend_r, pend_nxt;
  logic [pkst_pkg::KEY_AW-1:0]   pend_idx_r, pend_idx_nxt;
  logic                          hit_r, hit_nxt;
  logic [pkst_pkg::KEY_AW-1:0]   hit_idx_r, hit_idx_nxt;
  logic                          unk_r, unk_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [pkst_pkg::SERIAL_W-1:0] serial_r, serial_nxt;
  logic [pkst_pkg::MOD_W-1:0]    prev_mods_r, prev_mods_nxt;
  pkst_pkg::idx_arr_t            idx_r;

  logic                          press_r;
  logic [pkst_pkg::CODE_W-1:0]   code_r;
  logic [pkst_pkg::TIME_W-1:0]   time_r;
  logic [pkst_pkg::MOD_W-1:0]    mods_r;

  logic                          out_valid_r, out_valid_nxt;
  result_t                       out_r, out_nxt;
  logic                          out_load;

  logic                          ram_we;
  logic [pkst_pkg::KEY_AW-1:0]   ram_waddr;
  logic [pkst_pkg::CODE_W-1:0]   ram_wdata;
  logic [pkst_pkg::KEY_AW-1:0]   ram_raddr;
  logic [pkst_pkg::CODE_W-1:0]   ram_rdata;

  logic [pkst_pkg::CNT_W-1:0]    count_m1;
  logic                          in_xfer;
  logic                          out_free;
  logic                          mods_changed;
  pkst_pkg::masks_t              masks;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign count_m1     = count_r - pkst_pkg::CNT_W'(1);
  assign mods_changed = (mods_r != prev_mods_r);

  // scan reads walk the table; otherwise the last entry is read for a removal
  assign ram_raddr = (state_r == ST_SCAN) ? scan_idx_r[pkst_pkg::KEY_AW-1:0]
                                          : count_m1[pkst_pkg::KEY_AW-1:0];

  pkst_ram #(
    .WIDTH (pkst_pkg::CODE_W),
    .DEPTH (pkst_pkg::MAX_KEYS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pkst_modmap u_modmap (
    .mods  (mods_r),
    .idx   (idx_r),
    .masks (masks)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    unk_nxt       = unk_r;
    ovf_nxt       = ovf_r;
    serial_nxt    = serial_r;
    prev_mods_nxt = prev_mods_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[pkst_pkg::KEY_AW-1:0];
    ram_wdata     = code_r;
    out_load      = 1'b0;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          scan_idx_nxt = '0;
          pend_nxt     = 1'b0;
          hit_nxt      = 1'b0;
          unk_nxt      = 1'b0;
          ovf_nxt      = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // compare data read last cycle while the next read goes out
        if (pend_r && (ram_rdata == code_r)) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pend_idx_r;
          state_nxt   = ST_DECIDE;
        end else if (scan_idx_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_idx_r[pkst_pkg::KEY_AW-1:0];
          scan_idx_nxt = scan_idx_r + pkst_pkg::CNT_W'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (press_r && hit_r) begin
          // auto-repeat: nothing changes
          state_nxt = ST_IDLE;
        end else begin
          serial_nxt = serial_r + pkst_pkg::SERIAL_W'(1);
          state_nxt  = mods_changed ? ST_EMIT_MOD : ST_EMIT_KEY;
          if (press_r) begin
            if (count_r < pkst_pkg::CNT_W'(pkst_pkg::MAX_KEYS)) begin
              ram_we    = 1'b1;
              count_nxt = count_r + pkst_pkg::CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (hit_r) begin
            state_nxt = ST_MOVE;
          end else begin
            unk_nxt = 1'b1;
          end
        end
      end
      ST_MOVE: begin
        // last entry fills the released slot
        ram_we    = 1'b1;
        ram_waddr = hit_idx_r;
        ram_wdata = ram_rdata;
        count_nxt = count_m1;
        state_nxt = mods_changed ? ST_EMIT_MOD : ST_EMIT_KEY;
      end
      ST_EMIT_MOD: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_nxt       = '0;
          out_nxt.kind  = pkst_pkg::RESULT_MOD;
          out_nxt.serial = serial_r;
          out_nxt.dep   = masks.depressed;
          out_nxt.lck   = masks.locked;
          prev_mods_nxt = mods_r;
          state_nxt     = ST_EMIT_KEY;
        end
      end
      ST_EMIT_KEY: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_nxt         = '0;
          out_nxt.kind    = pkst_pkg::RESULT_KEY;
          out_nxt.code    = code_r;
          out_nxt.down    = press_r;
          out_nxt.ev_time = time_r;
          out_nxt.serial  = serial_r;
          out_nxt.unk     = unk_r;
          out_nxt.ovf     = ovf_r;
          out_nxt.last    = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_idx_r  <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      unk_r       <= 1'b0;
      ovf_r       <= 1'b0;
      serial_r    <= '0;
      prev_mods_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < pkst_pkg::NUM_REGS; i++) begin
        idx_r[i] <= pkst_pkg::IDX_UNMAPPED;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      unk_r       <= unk_nxt;
      ovf_r       <= ovf_nxt;
      serial_r    <= serial_nxt;
      prev_mods_r <= prev_mods_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready &&
          (cfg_ch.index < pkst_pkg::CFG_IDX_W'(pkst_pkg::NUM_REGS))) begin
        idx_r[cfg_ch.index[$clog2(pkst_pkg::NUM_REGS)-1:0]] <= cfg_ch.data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    out_r      <= out_nxt;
    if (in_xfer) begin
      press_r <= in_ch.pressed;
      code_r  <= in_ch.keycode;
      time_r  <= in_ch.timestamp;
      mods_r  <= in_ch.modifier_bits;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_kind     = out_r.kind;
  assign out_ch.key_code        = out_r.code;
  assign out_ch.key_down        = out_r.down;
  assign out_ch.event_time      = out_r.ev_time;
  assign out_ch.serial_number   = out_r.serial;
  assign out_ch.depressed_mask  = out_r.dep;
  assign out_ch.locked_mask     = out_r.lck;
  assign out_ch.unknown_release = out_r.unk;
  assign out_ch.table_overflow  = out_r.ovf;
  assign out_ch.last_of_run     = out_r.last;

endmodule

### tb/sv/tb_pressed_key_set_tracker.sv
// self-checking testbench of the pressed-key set tracker: directed table, then random phases
module tb_pressed_key_set_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES    = 40;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASE_EVENTS     = 450;
  localparam int NUM_PHASES       = 4;
  localparam int KEY_POOL         = 32;
  localparam int MAX_KEYCODE      = 767;

  typedef struct {
    logic                        pressed;
    logic [pkst_pkg::CODE_W-1:0] code;
    logic [pkst_pkg::TIME_W-1:0] stamp;
    logic [pkst_pkg::MOD_W-1:0]  mods;
  } key_event_t;

  typedef struct {
    logic                          kind;
    logic [pkst_pkg::CODE_W-1:0]   code;
    logic                          down;
    logic [pkst_pkg::TIME_W-1:0]   stamp;
    logic [pkst_pkg::SERIAL_W-1:0] serial;
    logic [pkst_pkg::MASK_W-1:0]   depressed;
    logic [pkst_pkg::MASK_W-1:0]   locked;
    logic                          unknown;
    logic                          overflow;
    logic                          last;
  } key_result_t;

  typedef struct {
    key_event_t ev;
    bit         typed;
    int         n_res;
    bit         unknown;
    bit         overflow;
  } dir_row_t;

  logic clk;
  logic rst_n;

  pkst_in_if  in_ch();
  pkst_out_if out_ch();
  pkst_cfg_if cfg_ch();

  pressed_key_set_tracker u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // tracker state as the testbench sees it
  logic [pkst_pkg::CODE_W-1:0]   held_keys [pkst_pkg::MAX_KEYS];
  int                            held_cnt;
  logic [pkst_pkg::MOD_W-1:0]    last_mods;
  logic [pkst_pkg::SERIAL_W-1:0] serial_ctr;
  pkst_pkg::idx_arr_t            mod_idx;

  key_result_t pending_results[$];
  int          err_cnt;
  bit          src_idles;
  bit          sink_idles;
  bit          long_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // updates the key table and serial, queues the results of one accepted event
  function automatic int track_event(key_event_t ev);
    key_result_t r;
    int          hit;
    int          i;
    int          b;
    int          n;
    logic        unk;
    logic        ovf;
    hit = -1;
    unk = 1'b0;
    ovf = 1'b0;
    n   = 0;
    for (i = 0; i < held_cnt; i++) begin
      if (hit < 0 && held_keys[i] == ev.code) hit = i;
    end
    if (ev.pressed) begin
      // auto-repeat leaves everything as it is
      if (hit >= 0) return 0;
      if (held_cnt < pkst_pkg::MAX_KEYS) begin
        held_keys[held_cnt] = ev.code;
        held_cnt++;
      end else begin
        ovf = 1'b1;
      end
    end else if (hit >= 0) begin
      held_keys[hit] = held_keys[held_cnt-1];
      held_cnt--;
    end else begin
      unk = 1'b1;
    end
    serial_ctr++;
    if (ev.mods != last_mods) begin
      r = '{default: '0};
      r.kind   = pkst_pkg::RESULT_MOD;
      r.serial = serial_ctr;
      for (b = 0; b < pkst_pkg::NUM_REGS; b++) begin
        if (ev.mods[b] && mod_idx[b] < pkst_pkg::IDX_UNMAPPED) begin
          if (b == pkst_pkg::LOCK_BIT) r.locked |= pkst_pkg::MASK_W'(1) << mod_idx[b];
          else r.depressed |= pkst_pkg::MASK_W'(1) << mod_idx[b];
        end
      end
      last_mods = ev.mods;
      pending_results.push_back(r);
      n = 1;
    end
    r = '{default: '0};
    r.kind     = pkst_pkg::RESULT_KEY;
    r.code     = ev.code;
    r.down     = ev.pressed;
    r.stamp    = ev.stamp;
    r.serial   = serial_ctr;
    r.unknown  = unk;
    r.overflow = ovf;
    r.last     = 1'b1;
    pending_results.push_back(r);
    return n + 1;
  endfunction

  function automatic dir_row_t row(int p, int code, logic [31:0] stamp,
                                   logic [pkst_pkg::MOD_W-1:0] mods,
                                   int typed, int n_res, int unk, int ovf);
    dir_row_t d;
    d.ev.pressed = (p != 0);
    d.ev.code    = pkst_pkg::CODE_W'(code);
    d.ev.stamp   = stamp;
    d.ev.mods    = mods;
    d.typed      = (typed != 0);
    d.n_res      = n_res;
    d.unknown    = (unk != 0);
    d.overflow   = (ovf != 0);
    return d;
  endfunction

  // valid stays high after the transfer unless a gap follows; the caller lowers it at the end
  task automatic offer_event(key_event_t ev, output int n);
    in_ch.valid         <= 1'b1;
    in_ch.pressed       <= ev.pressed;
    in_ch.keycode       <= ev.code;
    in_ch.timestamp     <= ev.stamp;
    in_ch.modifier_bits <= ev.mods;
    do @(posedge clk); while (!in_ch.ready);
    n = track_event(ev);
    if (src_idles && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic write_regs(pkst_pkg::idx_arr_t vals);
    int r;
    for (r = 0; r < pkst_pkg::NUM_REGS; r++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= pkst_pkg::CFG_IDX_W'(r);
      cfg_ch.data  <= vals[r];
      do @(posedge clk); while (!cfg_ch.ready);
      mod_idx[r] = vals[r];
    end
    // a write past the last register must not disturb anything
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= pkst_pkg::CFG_IDX_W'($urandom_range(pkst_pkg::NUM_REGS,
                                                        2**pkst_pkg::CFG_IDX_W - 1));
    cfg_ch.data  <= pkst_pkg::IDX_W'($urandom_range(0, 2**pkst_pkg::IDX_W - 1));
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    int k;
    for (k = 0; k < DRAIN_LIMIT && pending_results.size() != 0; k++) @(posedge clk);
    // a trailing auto-repeat may still be scanning the table
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    key_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("transfer with no result pending", out_ch.serial_number, '0);
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(out_ch.result_kind), 32'(want.kind));
        check_field("key_code", 32'(out_ch.key_code), 32'(want.code));
        check_field("key_down", 32'(out_ch.key_down), 32'(want.down));
        check_field("event_time", out_ch.event_time, want.stamp);
        check_field("serial_number", out_ch.serial_number, want.serial);
        check_field("depressed_mask", out_ch.depressed_mask, want.depressed);
        check_field("locked_mask", out_ch.locked_mask, want.locked);
        check_field("unknown_release", 32'(out_ch.unknown_release), 32'(want.unknown));
        check_field("table_overflow", 32'(out_ch.table_overflow), 32'(want.overflow));
        check_field("last_of_run", 32'(out_ch.last_of_run), 32'(want.last));
      end
    end
  end

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (sink_idles && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    dir_row_t                   rows[$];
    key_event_t                 ev;
    pkst_pkg::idx_arr_t         vals;
    logic [pkst_pkg::MOD_W-1:0] cur_mods;
    int                         n;
    int                         i;
    int                         r;
    int                         ph;
    int                         press_pct;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.pressed       <= 1'b0;
    in_ch.keycode       <= '0;
    in_ch.timestamp     <= '0;
    in_ch.modifier_bits <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= '0;
    cfg_ch.data         <= '0;
    err_cnt    = 0;
    src_idles  = 1'b1;
    sink_idles = 1'b1;
    long_hold  = 1'b0;
    held_cnt   = 0;
    last_mods  = '0;
    serial_ctr = '0;
    for (r = 0; r < pkst_pkg::NUM_REGS; r++) mod_idx[r] = pkst_pkg::IDX_UNMAPPED;
    for (r = 0; r < pkst_pkg::MAX_KEYS; r++) held_keys[r] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // shift 0, caps 31, ctrl 32, alt 63: the edges of the index range
    write_regs({6'd1, 6'd30, 6'd17, 6'd5, 6'd63, 6'd32, 6'd31, 6'd0});

    rows.push_back(row(1, 0, 32'h0, 8'h00, 1, 1, 0, 0));
    rows.push_back(row(1, 0, 32'h1234, 8'hff, 1, 0, 0, 0));        // auto-repeat
    rows.push_back(row(0, MAX_KEYCODE, 32'hffff_ffff, 8'hff, 1, 2, 1, 0)); // unknown release
    rows.push_back(row(0, 0, 32'h1, 8'hff, 1, 1, 0, 0));
    rows.push_back(row(1, MAX_KEYCODE, 32'h2, 8'h00, 1, 2, 0, 0));
    for (i = 1; i < pkst_pkg::MAX_KEYS; i++)
      rows.push_back(row(1, i * 51, 32'h0001_0000 * i,
                         pkst_pkg::MOD_W'(1 << (i % 8)), 0, 0, 0, 0));
    rows.push_back(row(1, 100, 32'h8000_0000, 8'h80, 1, 1, 0, 1)); // table full
    rows.push_back(row(1, MAX_KEYCODE, 32'h7fff_ffff, 8'h3c, 1, 0, 0, 0));
    rows.push_back(row(0, 255, 32'h5555_5555, 8'h80, 1, 1, 0, 0));
    rows.push_back(row(0, MAX_KEYCODE, 32'haaaa_aaaa, 8'h55, 0, 0, 0, 0));
    rows.push_back(row(0, 765, 32'h0f0f_0f0f, 8'haa, 0, 0, 0, 0));

    foreach (rows[k]) begin
      offer_event(rows[k].ev, n);
      if (rows[k].typed) begin
        check_field("directed result count", n, rows[k].n_res);
        if (n > 0) begin
          check_field("directed unknown_release", 32'(pending_results[$].unknown),
                      32'(rows[k].unknown));
          check_field("directed table_overflow", 32'(pending_results[$].overflow),
                      32'(rows[k].overflow));
        end
      end
    end
    in_ch.valid <= 1'b0;
    drain_results();

    cur_mods = last_mods;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      unique case (ph)
        0: vals = '0;
        1: vals = '1;
        2: for (r = 0; r < pkst_pkg::NUM_REGS; r++)
             vals[r] = pkst_pkg::IDX_W'($urandom_range(0, 2**pkst_pkg::IDX_W - 1));
        default: vals = {6'd32, 6'd2, 6'd8, 6'd24, 6'd16, 6'd31, 6'd0, 6'd7};
      endcase
      write_regs(vals);
      press_pct = (ph == 1) ? 70 : (ph == 2) ? 40 : 55;
      if (ph == 1) long_hold = 1'b1;
      if (ph == NUM_PHASES - 1) begin
        src_idles  = 1'b0;
        sink_idles = 1'b0;
      end
      for (i = 0; i < PHASE_EVENTS; i++) begin
        // mostly held keys are released and a small pool is pressed, so repeats and fills occur
        ev.pressed = ($urandom_range(0, 99) < press_pct);
        if (!ev.pressed && held_cnt > 0 && $urandom_range(0, 99) < 80)
          ev.code = held_keys[$urandom_range(0, held_cnt - 1)];
        else if ($urandom_range(0, 99) < 70)
          ev.code = pkst_pkg::CODE_W'($urandom_range(0, KEY_POOL - 1));
        else
          ev.code = pkst_pkg::CODE_W'($urandom_range(0, MAX_KEYCODE));
        ev.stamp = $urandom();
        if ($urandom_range(0, 99) < 30) cur_mods = pkst_pkg::MOD_W'($urandom_range(0, 255));
        ev.mods = cur_mods;
        if (ph == 2 && i == PHASE_EVENTS / 2) begin
          in_ch.valid <= 1'b0;
          drain_results();
        end
        offer_event(ev, n);
      end
      in_ch.valid <= 1'b0;
      drain_results();
    end

    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), '0);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
